// ===== design/brrc_pkg.sv =====
// Shared types and constants of the range rule classifier.
package brrc_pkg;

  localparam int MAX_RULES  = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W      = $clog2(MAX_RULES + 1);

  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_POLICY = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] record_value;
    logic        rule_action;
    logic [4:0]  rule_shift;
    logic [31:0] rule_mask;
    logic [31:0] rule_min;
    logic [31:0] rule_max;
  } in_t;

  typedef struct packed {
    logic       keep;
    logic       matched;
    logic [3:0] match_index;
    logic       status;
  } out_t;

  typedef struct packed {
    logic                  action;
    logic [4:0]            shift;
    logic [VALUE_BITS-1:0] mask;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } rule_t;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic                  found;
    logic                  keep;
    logic [IDX_W-1:0]      idx;
  } token_t;

endpackage

// ===== design/brrc_cell.sv =====
// One rule cell: holds a rule and tests the passing check token against it.
module brrc_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  brrc_pkg::rule_t         wr_rule,
  input  logic                    used,
  input  logic [brrc_pkg::IDX_W-1:0] cell_idx,
  input  brrc_pkg::token_t        tok_in,
  output brrc_pkg::token_t        tok_out
);

  brrc_pkg::rule_t  rule_r;
  brrc_pkg::token_t tok_r;
  brrc_pkg::token_t tok_nxt;
  logic [brrc_pkg::VALUE_BITS-1:0] bits;
  logic hit;

  // Extract the field and test the inclusive range.
  always_comb begin
    bits = (tok_in.value >> rule_r.shift) & rule_r.mask;
    hit  = used && !tok_in.found && (bits >= rule_r.lo) && (bits <= rule_r.hi);
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found | hit;
    if (hit) begin
      tok_nxt.keep = rule_r.action;
      tok_nxt.idx  = cell_idx;
    end
  end

  // Rule storage needs no reset: only written cells are consulted.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  // Advance the token one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.value <= tok_nxt.value;
    tok_r.found <= tok_nxt.found;
    tok_r.keep  <= tok_nxt.keep;
    tok_r.idx   <= tok_nxt.idx;
  end

  assign tok_out = tok_r;

endmodule

// ===== design/bitfield_range_rule_classifier_unit.sv =====
// Top level of the first-match range rule classifier: control and cell chain.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one request per
//   transaction: check a value, add a rule, clear the table or set the
//   default policy. Every request yields exactly one result transaction on
//   the output channel (out_valid / out_ready / out_data).
//   Rules live in a row of MAX_RULES cells, one rule per cell, in order.
//   A check launches a token that walks the row one cell per cycle; the
//   first cell whose range holds the extracted bits marks the token, later
//   cells leave it alone, and the tail of the row gives the decision.
//   A check's token passes from the token register through every cell
//   register in turn before its result reaches the output register; add,
//   clear and policy show theirs the cycle after the accept edge. One
//   request is in flight at a time, so a new request is not taken before
//   the previous result has been handed over.
//   Reset empties the table and sets the default policy to keep. While the
//   receiver stalls the result is held in the output register and no new
//   request is taken.
module bitfield_range_rule_classifier_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  brrc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output brrc_pkg::out_t  out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [brrc_pkg::CNT_W-1:0] rules_used_r, rules_used_nxt;
  logic default_keep_r, default_keep_nxt;
  brrc_pkg::out_t out_r, out_nxt;
  brrc_pkg::token_t inj_r, inj_nxt;
  brrc_pkg::token_t tok [brrc_pkg::MAX_RULES+1];
  brrc_pkg::rule_t new_rule;
  logic in_acc;
  logic add_ok;
  logic table_full;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign out_data   = out_r;
  assign in_acc     = in_valid && in_ready;
  assign table_full = (rules_used_r == brrc_pkg::CNT_W'(brrc_pkg::MAX_RULES));
  assign add_ok     = in_acc && (in_data.req_type == brrc_pkg::REQ_ADD) && !table_full;

  // Fit the rule fields to the value width.
  always_comb begin
    new_rule.action = in_data.rule_action;
    new_rule.shift  = in_data.rule_shift;
    new_rule.mask   = brrc_pkg::VALUE_BITS'(in_data.rule_mask);
    new_rule.lo     = brrc_pkg::VALUE_BITS'(in_data.rule_min);
    new_rule.hi     = brrc_pkg::VALUE_BITS'(in_data.rule_max);
  end

  // Head of the row: the token register feeds the first cell.
  assign tok[0] = inj_r;

  for (genvar i = 0; i < brrc_pkg::MAX_RULES; i++) begin : g_cell
    brrc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (add_ok && (rules_used_r == brrc_pkg::CNT_W'(i))),
      .wr_rule  (new_rule),
      .used     (brrc_pkg::CNT_W'(i) < rules_used_r),
      .cell_idx (brrc_pkg::IDX_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    rules_used_nxt   = rules_used_r;
    default_keep_nxt = default_keep_r;
    out_nxt          = out_r;
    inj_nxt          = inj_r;
    inj_nxt.valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_nxt = '0;
          case (in_data.req_type)
            brrc_pkg::REQ_CHECK: begin
              // Launch a token carrying the default decision.
              inj_nxt.valid = 1'b1;
              inj_nxt.value = brrc_pkg::VALUE_BITS'(in_data.record_value);
              inj_nxt.found = 1'b0;
              inj_nxt.keep  = default_keep_r;
              inj_nxt.idx   = '0;
              state_nxt     = ST_RUN;
            end
            brrc_pkg::REQ_ADD: begin
              if (table_full) begin
                out_nxt.status = 1'b1;
              end else begin
                rules_used_nxt = rules_used_r + brrc_pkg::CNT_W'(1);
              end
              state_nxt = ST_OUT;
            end
            brrc_pkg::REQ_CLEAR: begin
              rules_used_nxt   = '0;
              default_keep_nxt = 1'b1;
              state_nxt        = ST_OUT;
            end
            default: begin
              default_keep_nxt = in_data.rule_action;
              state_nxt        = ST_OUT;
            end
          endcase
        end
      end
      ST_RUN: begin
        // Wait for the token to leave the last cell.
        if (tok[brrc_pkg::MAX_RULES].valid) begin
          out_nxt.keep        = tok[brrc_pkg::MAX_RULES].keep;
          out_nxt.matched     = tok[brrc_pkg::MAX_RULES].found;
          out_nxt.match_index = 4'(tok[brrc_pkg::MAX_RULES].idx);
          out_nxt.status      = 1'b0;
          state_nxt           = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold the result until the receiver takes it.
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rules_used_r   <= '0;
      default_keep_r <= 1'b1;
      inj_r.valid    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rules_used_r   <= rules_used_nxt;
      default_keep_r <= default_keep_nxt;
      inj_r.valid    <= inj_nxt.valid;
    end
    inj_r.value <= inj_nxt.value;
    inj_r.found <= inj_nxt.found;
    inj_r.keep  <= inj_nxt.keep;
    inj_r.idx   <= inj_nxt.idx;
    out_r       <= out_nxt;
  end

  // A non-check request must produce its result the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.req_type != brrc_pkg::REQ_CHECK)) |=> out_valid)
    else $error("non-check request did not complete in one cycle");

  // The rule count never exceeds the row length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rules_used_r <= brrc_pkg::CNT_W'(brrc_pkg::MAX_RULES))
    else $error("rule count beyond table size");

  // A dropped add never reports a match or a keep decision.
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (!out_data.matched && !out_data.keep))
    else $error("full status mixed with check result");

  // The chain tail only fires while a check is in flight.
  a_tail_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok[brrc_pkg::MAX_RULES].valid |-> (state_r == ST_RUN))
    else $error("token left the row outside a check");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the first-match range rule classifier with random stimulus.
module tb_top;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 475;
  localparam int IDLE_PERCENT = 36;
  // Window of transactions during which neither side idles.
  localparam int QUIET_FIRST  = 250;
  localparam int QUIET_LAST   = 350;
  // A check walks the whole cell row; allow a few times that after the last result.
  localparam int DRAIN_CYCLES = 4 * (brrc_pkg::MAX_RULES + 3);
  // Far beyond the slowest legal run of ~525 transactions.
  localparam int LIMIT_NS     = 3_000_000;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  brrc_pkg::in_t   in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  brrc_pkg::out_t  out_data;

  // Requests waiting for the driver, and decisions waiting for the monitor.
  brrc_pkg::in_t   request_queue[$];
  brrc_pkg::out_t  expected_decisions[$];

  int     total_requests  = 0;
  int     accepted_count  = 0;
  int     results_seen    = 0;
  int     error_count     = 0;

  // Coverage tallies kept by the predictor.
  int     n_check   = 0;
  int     n_matched = 0;
  int     n_add     = 0;
  int     n_full    = 0;
  int     n_clear   = 0;
  int     n_policy  = 0;

  // Predictor state: the rule table, its fill level and the default policy.
  brrc_pkg::rule_t  rule_table [brrc_pkg::MAX_RULES];
  int               rules_stored   = 0;
  logic             default_policy = 1'b1;

  // Shadow of the table as the stimulus generator expects it, used to aim checks.
  brrc_pkg::rule_t  plan_rules [brrc_pkg::MAX_RULES];
  int               plan_count = 0;

  bitfield_range_rule_classifier_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predict the decision of one accepted request and advance the predictor state.
  function automatic brrc_pkg::out_t classify_request(input brrc_pkg::in_t req);
    brrc_pkg::out_t res;
    logic [31:0]    bits;
    res = '0;
    case (req.req_type)
      brrc_pkg::REQ_CHECK: begin
        n_check++;
        res.keep = default_policy;
        // Lowest-numbered rule whose inclusive range holds the extracted bits wins.
        for (int i = 0; i < rules_stored; i++) begin
          bits = (req.record_value >> rule_table[i].shift) & rule_table[i].mask;
          if (bits >= rule_table[i].lo && bits <= rule_table[i].hi) begin
            res.keep        = rule_table[i].action;
            res.matched     = 1'b1;
            res.match_index = 4'(i);
            n_matched++;
            break;
          end
        end
      end
      brrc_pkg::REQ_ADD: begin
        n_add++;
        if (rules_stored >= brrc_pkg::MAX_RULES) begin
          // Table full: drop the rule and flag it.
          res.status = 1'b1;
          n_full++;
        end else begin
          rule_table[rules_stored].action = req.rule_action;
          rule_table[rules_stored].shift  = req.rule_shift;
          rule_table[rules_stored].mask   = req.rule_mask;
          rule_table[rules_stored].lo     = req.rule_min;
          rule_table[rules_stored].hi     = req.rule_max;
          rules_stored++;
        end
      end
      brrc_pkg::REQ_CLEAR: begin
        // Empty the table and fall back to keep.
        n_clear++;
        rules_stored   = 0;
        default_policy = 1'b1;
      end
      default: begin
        n_policy++;
        default_policy = req.rule_action;
      end
    endcase
    return res;
  endfunction

  // Fully random request: every field of every type toggles.
  function automatic brrc_pkg::in_t random_request();
    brrc_pkg::in_t r;
    r.req_type     = 2'($urandom);
    r.record_value = $urandom;
    r.rule_action  = 1'($urandom);
    r.rule_shift   = 5'($urandom);
    r.rule_mask    = $urandom;
    r.rule_min     = $urandom;
    r.rule_max     = $urandom;
    return r;
  endfunction

  // Append a request and track the table the generator expects it to build.
  task automatic queue_request(input brrc_pkg::in_t r);
    request_queue.push_back(r);
    if (r.req_type == brrc_pkg::REQ_CLEAR) begin
      plan_count = 0;
    end else if (r.req_type == brrc_pkg::REQ_ADD && plan_count < brrc_pkg::MAX_RULES) begin
      plan_rules[plan_count].action = r.rule_action;
      plan_rules[plan_count].shift  = r.rule_shift;
      plan_rules[plan_count].mask   = r.rule_mask;
      plan_rules[plan_count].lo     = r.rule_min;
      plan_rules[plan_count].hi     = r.rule_max;
      plan_count++;
    end
  endtask

  task automatic queue_add(input logic act, input logic [4:0] sh, input logic [31:0] msk,
                           input logic [31:0] lo, input logic [31:0] hi);
    brrc_pkg::in_t r;
    r             = random_request();
    r.req_type    = brrc_pkg::REQ_ADD;
    r.rule_action = act;
    r.rule_shift  = sh;
    r.rule_mask   = msk;
    r.rule_min    = lo;
    r.rule_max    = hi;
    queue_request(r);
  endtask

  task automatic queue_check(input logic [31:0] value);
    brrc_pkg::in_t r;
    r              = random_request();
    r.req_type     = brrc_pkg::REQ_CHECK;
    r.record_value = value;
    queue_request(r);
  endtask

  // Clear or policy request; the action bit carries the new default for a policy.
  task automatic queue_control(input logic [1:0] kind, input logic act);
    brrc_pkg::in_t r;
    r             = random_request();
    r.req_type    = kind;
    r.rule_action = act;
    queue_request(r);
  endtask

  // Driver: present one request per transaction, hold it until accepted, idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_decisions.push_back(classify_request(in_data));
        accepted_count++;
      end
      // Load the next request only when the slot is free after this edge.
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 &&
            ((accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) ||
             $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          in_data  <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction; stall at random.
  always @(posedge clk) begin : monitor
    brrc_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_decisions.size() == 0) begin
          $error("result transaction with no request pending: %p", out_data);
          error_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (out_data.keep !== want.keep) begin
            $error("keep: expected %0b, got %0b", want.keep, out_data.keep);
            error_count++;
          end
          if (out_data.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, out_data.matched);
            error_count++;
          end
          if (out_data.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index,
                   out_data.match_index);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_data.status);
            error_count++;
          end
        end
      end
      out_ready <= (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) ||
                   ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    brrc_pkg::rule_t pick;
    logic [31:0]     msk, lo, hi, a, b, value;
    longint unsigned span;
    int              random_start, n_rules, n_chk;

    // Directed part: empty table under both policies.
    queue_check(32'h0000_0000);
    queue_control(brrc_pkg::REQ_POLICY, 1'b0);
    queue_check(32'hFFFF_FFFF);
    // Inverted range, top-bit rule at the widest shift, zero mask, single-point range.
    queue_add(1'b0, 5'd0,  32'hFFFF_FFFF, 32'd10, 32'd5);
    queue_add(1'b1, 5'd31, 32'h0000_0001, 32'd1, 32'd1);
    queue_add(1'b1, 5'd0,  32'h0000_0000, 32'd1, 32'hFFFF_FFFF);
    queue_add(1'b0, 5'd4,  32'h0000_00FF, 32'h14, 32'h14);
    queue_check(32'h8000_0000);
    queue_check(32'h0000_0140);
    queue_check(32'h0000_0000);
    // Fill the table; the last slot is a catch-all so the highest index decides.
    for (int k = 4; k < brrc_pkg::MAX_RULES - 1; k++) begin
      queue_add(1'b0, 5'(k), 32'h0000_00FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    queue_add(1'b1, 5'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_check(32'h0000_0000);
    // Table full: drop the rule.
    queue_add(1'b1, 5'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    // Clear restores keep as default.
    queue_control(brrc_pkg::REQ_CLEAR, 1'b0);
    queue_check(32'hFFFF_FFFF);

    // Random part: mostly table builds followed by aimed checks, the rest noise.
    random_start = request_queue.size();
    while (request_queue.size() < random_start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_control(brrc_pkg::REQ_CLEAR, 1'($urandom));
        if ($urandom_range(0, 1) == 1) queue_control(brrc_pkg::REQ_POLICY, 1'($urandom));
        if ($urandom_range(0, 99) < 15) begin
          n_rules = $urandom_range(brrc_pkg::MAX_RULES + 1, brrc_pkg::MAX_RULES + 4);
        end else begin
          n_rules = $urandom_range(1, brrc_pkg::MAX_RULES);
        end
        for (int k = 0; k < n_rules; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: msk = 32'hFFFF_FFFF;
            3:       msk = 32'h0000_0000;
            4, 5, 6: msk = (32'h1 << $urandom_range(1, 8)) - 32'h1;
            default: msk = $urandom;
          endcase
          a = $urandom & msk;
          b = $urandom & msk;
          case ($urandom_range(0, 4))
            0: begin
              // Inverted (or single point when equal).
              lo = (a > b) ? a : b;
              hi = (a > b) ? b : a;
            end
            1: begin
              lo = a;
              hi = a;
            end
            2: begin
              lo = $urandom;
              hi = $urandom;
            end
            default: begin
              lo = a;
              hi = a | b;
            end
          endcase
          queue_add(1'($urandom), 5'($urandom), msk, lo, hi);
        end
        n_chk = $urandom_range(2, 10);
        for (int k = 0; k < n_chk; k++) begin
          value = $urandom;
          if (plan_count > 0 && $urandom_range(0, 99) < 60) begin
            // Aim at a stored rule: place an in-range field under its mask and shift.
            pick = plan_rules[$urandom_range(0, plan_count - 1)];
            if (pick.lo <= pick.hi) begin
              span  = 64'(pick.hi) - 64'(pick.lo) + 64'd1;
              a     = pick.lo + 32'(64'($urandom) % span);
              value = (value & ~(pick.mask << pick.shift)) | ((a & pick.mask) << pick.shift);
            end
          end else begin
            case ($urandom_range(0, 7))
              0:       value = 32'h0000_0000;
              1:       value = 32'hFFFF_FFFF;
              default: value = $urandom;
            endcase
          end
          queue_check(value);
          if ($urandom_range(0, 99) < 8) queue_control(brrc_pkg::REQ_POLICY, 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4)) queue_request(random_request());
      end
    end
    total_requests = request_queue.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every decision to come back, then drain.
    while (accepted_count < total_requests) @(posedge clk);
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d checks, %0d decided by a rule, the rest by default.",
             accepted_count, n_check, n_matched);
    $display("Also %0d adds (%0d dropped on a full table), %0d clears, %0d policy changes.",
             n_add, n_full, n_clear, n_policy);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
